// ===== hdl/hrtf_nearest_direction_select_macros.svh =====
// Assertion helpers used by hdl/hrtf_nearest_direction_select.sv.
`ifndef HRTF_NEAREST_DIRECTION_SELECT_MACROS_SVH
`define HRTF_NEAREST_DIRECTION_SELECT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HNDS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HNDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hnds_pkg.sv =====
`timescale 1ns / 1ps

package hnds_pkg;

    localparam int ELEV_W      = 8;
    localparam int AZIM_W      = 9;
    localparam int QAZ_W       = 13;
    localparam int QEL_W       = 12;
    localparam int COUNT_W     = 11;
    localparam int SLOT_W      = 10;
    localparam int ENTRY_W     = ELEV_W + AZIM_W;
    // Signed working width of the shared subtractor, magnitude width of a distance.
    localparam int DIFF_W      = 15;
    localparam int DIST_W      = DIFF_W - 1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ELEV,
        ST_AZIM,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/hnds_ram.sv =====
`timescale 1ns / 1ps

module hnds_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/hrtf_nearest_direction_select.sv =====
`timescale 1ns / 1ps
// Write word (req_type 0): taken while idle, no result; busy stays low.
// Query word: done rises after both sweeps over n = min(entry_count, MAX_ENTRIES) entries,
// and the sweeps are skipped for an empty table; busy holds off the next word until idle.
// Cost: two sweeps over the direction RAM, one entry per cycle through one read port.
// The receiver cannot stall: done, filter_index, found and flip_channels are valid one cycle.
// rst_n clears the sequencer and entry_count asynchronously; RAM is undefined until written.

`include "hrtf_nearest_direction_select_macros.svh"

module hrtf_nearest_direction_select #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // command side
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic [hnds_pkg::SLOT_W-1:0]          entry_index,
    input  logic signed [hnds_pkg::ELEV_W-1:0]   entry_elevation,
    input  logic [hnds_pkg::AZIM_W-1:0]          entry_azimuth,
    input  logic signed [hnds_pkg::QAZ_W-1:0]    query_azimuth,
    input  logic signed [hnds_pkg::QEL_W-1:0]    query_elevation,
    // configuration
    input  logic                                 cfg_write,
    input  logic [hnds_pkg::COUNT_W-1:0]         cfg_data,
    // result side
    output logic                                 done,
    output logic [hnds_pkg::SLOT_W-1:0]          filter_index,
    output logic                                 found,
    output logic                                 flip_channels
);

    import hnds_pkg::*;

    // Address width of the table and width of a counter that can hold the depth itself.
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [COUNT_W-1:0]         entry_count_reg;
    logic [CW-1:0]              n_reg, n_next;          // saturated entry count
    logic [CW-1:0]              issue_reg, issue_next;  // next RAM address to read
    logic                       rd_valid_reg, rd_valid_next;
    logic [AW-1:0]              rd_idx_reg, rd_idx_next; // index of the word now on rdata
    logic                       have_reg, have_next;    // pass 1 picked an elevation
    logic                       got_reg, got_next;      // pass 2 picked an entry
    logic [DIST_W-1:0]          best_d_reg, best_d_next;
    logic signed [ELEV_W-1:0]   best_el_reg, best_el_next;
    logic [AW-1:0]              best_idx_reg, best_idx_next;
    logic [QAZ_W-1:0]           qaz_reg, qaz_next;      // mirrored query azimuth, magnitude
    logic signed [QEL_W-1:0]    qel_reg, qel_next;
    logic                       flip_reg, flip_next;

    // ---------------------------------------------------------------
    // Decoded controls
    // ---------------------------------------------------------------
    logic accept;
    logic pass_elev;
    logic pass_azim;
    logic issuing;
    logic pass_end;

    // ---------------------------------------------------------------
    // Direction RAM: elevation in the upper bits, azimuth below
    // ---------------------------------------------------------------
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ENTRY_W-1:0]         ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [ENTRY_W-1:0]         ram_rdata;
    logic signed [ELEV_W-1:0]   rd_el;
    logic [AZIM_W-1:0]          rd_az;

    // ---------------------------------------------------------------
    // Shared distance unit
    // ---------------------------------------------------------------
    logic signed [DIFF_W-1:0]   op_a;
    logic signed [DIFF_W-1:0]   op_b;
    logic signed [DIFF_W-1:0]   diff;
    logic [DIST_W-1:0]          dist_mag;
    logic                       closer;

    logic [CW-1:0]              n_sat;
    logic [QAZ_W-1:0]           qaz_mag;

    assign accept = start && !busy;

    // Drop writes to slots beyond the table depth.
    assign ram_we    = accept && (req_type == REQ_WRITE)
                       && (32'(entry_index) < MAX_ENTRIES);
    assign ram_waddr = AW'(entry_index);
    assign ram_wdata = {entry_elevation, entry_azimuth};
    assign ram_raddr = issue_reg[AW-1:0];

    hnds_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_el = ram_rdata[ENTRY_W-1 -: ELEV_W];
    assign rd_az = ram_rdata[AZIM_W-1:0];

    // Clamp the count register to the table depth.
    assign n_sat = (32'(entry_count_reg) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                         : CW'(entry_count_reg);

    // Mirror a negative azimuth; the most negative code becomes its plain magnitude.
    assign qaz_mag = query_azimuth[QAZ_W-1] ? QAZ_W'(-query_azimuth) : QAZ_W'(query_azimuth);

    // Shared subtractor: stored value in sixteenths against the query, then magnitude.
    always_comb
    begin
        if (pass_elev)
        begin
            op_a = {{(DIFF_W - ELEV_W - 4){rd_el[ELEV_W-1]}}, rd_el, 4'b0000};
            op_b = {{(DIFF_W - QEL_W){qel_reg[QEL_W-1]}}, qel_reg};
        end
        else
        begin
            op_a = {{(DIFF_W - AZIM_W - 4){1'b0}}, rd_az, 4'b0000};
            op_b = {{(DIFF_W - QAZ_W){1'b0}}, qaz_reg};
        end
        diff     = op_a - op_b;
        dist_mag = diff[DIFF_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
    end

    // Strict less-than: ties keep the earlier entry.
    assign closer = dist_mag < best_d_reg;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    assign pass_end = (issue_reg == n_reg) && !rd_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_QUERY))
                begin
                    state_next = (n_sat == '0) ? ST_DONE : ST_ELEV;
                end
            end
            ST_ELEV:
            begin
                if (pass_end)
                begin
                    state_next = ST_AZIM;
                end
            end
            ST_AZIM:
            begin
                if (pass_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: decoded outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        busy      = 1'b1;
        pass_elev = 1'b0;
        pass_azim = 1'b0;
        done      = 1'b0;
        unique case (state_reg)
            ST_IDLE: busy      = 1'b0;
            ST_ELEV: pass_elev = 1'b1;
            ST_AZIM: pass_azim = 1'b1;
            ST_DONE: done      = 1'b1;
            default: busy      = 1'b1;
        endcase
    end

    assign issuing = (pass_elev || pass_azim) && (issue_reg < n_reg);

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb
    begin
        n_next        = n_reg;
        issue_next    = issue_reg;
        rd_valid_next = issuing;
        rd_idx_next   = issue_reg[AW-1:0];
        have_next     = have_reg;
        got_next      = got_reg;
        best_d_next   = best_d_reg;
        best_el_next  = best_el_reg;
        best_idx_next = best_idx_reg;
        qaz_next      = qaz_reg;
        qel_next      = qel_reg;
        flip_next     = flip_reg;

        if (accept && (req_type == REQ_QUERY))
        begin
            // Latch the query and arm the first sweep.
            n_next        = n_sat;
            issue_next    = '0;
            have_next     = 1'b0;
            got_next      = 1'b0;
            best_idx_next = '0;
            qaz_next      = qaz_mag;
            qel_next      = query_elevation;
            flip_next     = query_azimuth[QAZ_W-1];
        end

        if (issuing)
        begin
            issue_next = issue_reg + CW'(1);
        end

        // Pass 1: nearest stored elevation.
        if (pass_elev && rd_valid_reg && (!have_reg || closer))
        begin
            have_next    = 1'b1;
            best_d_next  = dist_mag;
            best_el_next = rd_el;
        end

        // Pass 2: nearest azimuth among entries at the chosen elevation.
        if (pass_azim && rd_valid_reg && (rd_el == best_el_reg) && (!got_reg || closer))
        begin
            got_next      = 1'b1;
            best_d_next   = dist_mag;
            best_idx_next = rd_idx_reg;
        end

        // Rewind the address counter for the second sweep.
        if (pass_elev && pass_end)
        begin
            issue_next = '0;
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            n_reg           <= '0;
            issue_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            have_reg        <= 1'b0;
            got_reg         <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            have_reg     <= have_next;
            got_reg      <= got_next;
            if (cfg_write)
            begin
                entry_count_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        best_d_reg   <= best_d_next;
        best_el_reg  <= best_el_next;
        best_idx_reg <= best_idx_next;
        qaz_reg      <= qaz_next;
        qel_reg      <= qel_next;
        flip_reg     <= flip_next;
    end

    // ---------------------------------------------------------------
    // Result word
    // ---------------------------------------------------------------
    assign found         = have_reg;
    assign filter_index  = have_reg ? SLOT_W'(best_idx_reg) : '0;
    assign flip_channels = flip_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `HNDS_ASSERT_NEXT(a_done_single, done, !done, "done held longer than one cycle")
    `HNDS_ASSERT_SAME(a_read_busy, rd_valid_reg, busy && !done, "RAM read outside a sweep")
    `HNDS_ASSERT_SAME(a_issue_bound, busy, issue_reg <= n_reg, "read address ran past the count")
    `HNDS_ASSERT_SAME(a_empty_not_found, done && (n_reg == '0), !found,
        "empty table reported a hit")
    `HNDS_ASSERT_NEXT(a_query_busy, accept && (req_type == REQ_QUERY), busy,
        "query accepted without going busy")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import hnds_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int RANDOM_WORDS = 290;
    // A write word lands in the RAM at the edge that takes it; SETTLE gives it margin.
    localparam int SETTLE       = 4;
    // Every word as a full-table query under the longest gaps stays well below this limit.
    localparam int CYCLE_LIMIT  = 10000000;

    typedef struct packed {
        logic [SLOT_W-1:0] index;
        logic              found;
        logic              flip;
    } pick_t;

    // Shadow copy of the direction table plus the entry count, and the picks
    // still owed by the block, oldest first.
    class direction_board;
        int          elev_tab[TABLE_DEPTH];
        int          azim_tab[TABLE_DEPTH];
        int unsigned entry_count;
        pick_t       pick_q[$];
        int          mismatch_count;

        function void set_count(input int unsigned n);
            entry_count = n & 32'h7FF;
        endfunction

        function int pending();
            return pick_q.size();
        endfunction

        // Two sweeps: nearest elevation first, then nearest azimuth among the
        // entries at exactly that elevation. Strict less-than keeps the first.
        function pick_t nearest_entry(input logic signed [QAZ_W-1:0] q_az,
                                      input logic signed [QEL_W-1:0] q_el);
            int    az_q, el_q, n, d, best_d, best_el, best_i;
            bit    have, got;
            pick_t p;
            az_q = int'(q_az);
            el_q = int'(q_el);
            p.flip = (az_q < 0);
            if (p.flip)
            begin
                az_q = -az_q;
            end
            n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
            have = 0;
            got = 0;
            best_d = 0;
            best_el = 0;
            best_i = 0;
            for (int i = 0; i < n; i++)
            begin
                d = elev_tab[i] * 16 - el_q;
                if (d < 0)
                begin
                    d = -d;
                end
                if (!have || d < best_d)
                begin
                    have = 1;
                    best_d = d;
                    best_el = elev_tab[i];
                end
            end
            for (int i = 0; i < n; i++)
            begin
                if (elev_tab[i] == best_el)
                begin
                    d = azim_tab[i] * 16 - az_q;
                    if (d < 0)
                    begin
                        d = -d;
                    end
                    if (!got || d < best_d)
                    begin
                        got = 1;
                        best_d = d;
                        best_i = i;
                    end
                end
            end
            p.found = have;
            p.index = have ? best_i[SLOT_W-1:0] : '0;
            return p;
        endfunction

        function void note_word(input logic rq,
                                input logic [SLOT_W-1:0] idx,
                                input logic signed [ELEV_W-1:0] el,
                                input logic [AZIM_W-1:0] az,
                                input logic signed [QAZ_W-1:0] q_az,
                                input logic signed [QEL_W-1:0] q_el);
            if (rq == REQ_WRITE)
            begin
                elev_tab[idx] = int'(el);
                azim_tab[idx] = int'(az);
            end
            else
            begin
                pick_q.push_back(nearest_entry(q_az, q_el));
            end
        endfunction

        function void check_pick(input logic [SLOT_W-1:0] idx, input logic fnd,
                                 input logic flp);
            pick_t want;
            if (pick_q.size() == 0)
            begin
                $error("result word with nothing owed: filter_index %0d found %0b",
                       idx, fnd);
                mismatch_count++;
                return;
            end
            want = pick_q.pop_front();
            if (idx !== want.index)
            begin
                $error("filter_index: expected %0d, got %0d", want.index, idx);
                mismatch_count++;
            end
            if (fnd !== want.found)
            begin
                $error("found: expected %0b, got %0b", want.found, fnd);
                mismatch_count++;
            end
            if (flp !== want.flip)
            begin
                $error("flip_channels: expected %0b, got %0b", want.flip, flp);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     req_type;
    logic [SLOT_W-1:0]        entry_index;
    logic signed [ELEV_W-1:0] entry_elevation;
    logic [AZIM_W-1:0]        entry_azimuth;
    logic signed [QAZ_W-1:0]  query_azimuth;
    logic signed [QEL_W-1:0]  query_elevation;
    logic                     cfg_write;
    logic [COUNT_W-1:0]       cfg_data;
    logic                     done;
    logic [SLOT_W-1:0]        filter_index;
    logic                     found;
    logic                     flip_channels;

    direction_board           board;
    bit                       idle_on;
    int                       words_sent;
    int                       cycle_count;
    // Elevations and azimuths that most entries and queries are built from,
    // so that ties and crowded elevations come up often.
    logic signed [ELEV_W-1:0] elev_pool[4];
    logic [AZIM_W-1:0]        azim_pool[4];

    hrtf_nearest_direction_select #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .entry_index    (entry_index),
        .entry_elevation(entry_elevation),
        .entry_azimuth  (entry_azimuth),
        .query_azimuth  (query_azimuth),
        .query_elevation(query_elevation),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .done           (done),
        .filter_index   (filter_index),
        .found          (found),
        .flip_channels  (flip_channels)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs or drops a result.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Results cannot be held off: take every done pulse as it comes.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            board.check_pick(filter_index, found, flip_channels);
        end
    end

    // Present one word and hold it until the block takes it. Start stays high
    // across back-to-back words; it drops when a gap is inserted or load_count runs.
    task automatic push_word(input logic rq, input logic [SLOT_W-1:0] idx,
                             input logic [ELEV_W-1:0] el, input logic [AZIM_W-1:0] az,
                             input logic [QAZ_W-1:0] q_az, input logic [QEL_W-1:0] q_el);
        if (idle_on && $urandom_range(0, 99) < 34)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_type        <= rq;
        entry_index     <= idx;
        entry_elevation <= el;
        entry_azimuth   <= az;
        query_azimuth   <= q_az;
        query_elevation <= q_el;
        start           <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        board.note_word(rq, idx, el, az, q_az, q_el);
        words_sent++;
    endtask

    // Query fields carry junk on a write; the block must ignore them.
    task automatic write_entry(input logic [SLOT_W-1:0] idx, input logic [ELEV_W-1:0] el,
                               input logic [AZIM_W-1:0] az);
        logic [QAZ_W-1:0] junk_az;
        logic [QEL_W-1:0] junk_el;
        junk_az = QAZ_W'($urandom);
        junk_el = QEL_W'($urandom);
        push_word(REQ_WRITE, idx, el, az, junk_az, junk_el);
    endtask

    // Entry fields carry junk on a query.
    task automatic ask_nearest(input logic [QAZ_W-1:0] q_az, input logic [QEL_W-1:0] q_el);
        logic [SLOT_W-1:0] junk_idx;
        logic [ELEV_W-1:0] junk_el;
        logic [AZIM_W-1:0] junk_az;
        junk_idx = SLOT_W'($urandom);
        junk_el  = ELEV_W'($urandom);
        junk_az  = AZIM_W'($urandom);
        push_word(REQ_QUERY, junk_idx, junk_el, junk_az, q_az, q_el);
    endtask

    // Change entry_count only with the block idle: drop start, drain every
    // owed result, let a trailing write settle, then pulse the write enable.
    task automatic load_count(input int unsigned n);
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_data  <= n[COUNT_W-1:0];
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_count(n);
    endtask

    function automatic logic [ELEV_W-1:0] pick_elev();
        logic [ELEV_W-1:0] v;
        if ($urandom_range(0, 3) != 0)
        begin
            v = elev_pool[$urandom_range(0, 3)];
        end
        else
        begin
            v = ELEV_W'($urandom_range(0, 255));
        end
        return v;
    endfunction

    function automatic logic [AZIM_W-1:0] pick_azim();
        logic [AZIM_W-1:0] v;
        if ($urandom_range(0, 2) == 0)
        begin
            v = azim_pool[$urandom_range(0, 3)];
        end
        else
        begin
            v = AZIM_W'($urandom_range(0, 511));
        end
        return v;
    endfunction

    // Near a pooled elevation, exactly between two of them, or anywhere.
    function automatic logic [QEL_W-1:0] pick_query_elev();
        int a, b, v;
        a = int'(elev_pool[$urandom_range(0, 3)]);
        b = int'(elev_pool[$urandom_range(0, 3)]);
        case ($urandom_range(0, 4))
            0, 1:    v = a * 16 + int'($urandom_range(0, 24)) - 12;
            2:       v = (a + b) * 8;
            default: v = int'($urandom_range(0, 4095));
        endcase
        return v[QEL_W-1:0];
    endfunction

    // Same idea for azimuth, mirrored to negative half the time.
    function automatic logic [QAZ_W-1:0] pick_query_azim();
        int a, b, v;
        a = int'(azim_pool[$urandom_range(0, 3)]);
        b = int'(azim_pool[$urandom_range(0, 3)]);
        case ($urandom_range(0, 4))
            0, 1:    v = a * 16 + int'($urandom_range(0, 24)) - 12;
            2:       v = (a + b) * 8;
            default: v = int'($urandom_range(0, 8191));
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            v = -v;
        end
        return v[QAZ_W-1:0];
    endfunction

    function automatic void refresh_pools();
        for (int k = 0; k < 4; k++)
        begin
            elev_pool[k] = ELEV_W'($urandom_range(0, 255));
            azim_pool[k] = AZIM_W'($urandom_range(0, 511));
        end
    endfunction

    initial
    begin
        int unsigned n;
        int          queries;
        int          phase;

        board           = new();
        idle_on         = 1'b1;
        words_sent      = 0;
        cycle_count     = 0;
        rst_n           <= 1'b0;
        start           <= 1'b0;
        req_type        <= REQ_WRITE;
        entry_index     <= '0;
        entry_elevation <= '0;
        entry_azimuth   <= '0;
        query_azimuth   <= '0;
        query_elevation <= '0;
        cfg_write       <= 1'b0;
        cfg_data        <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table after reset: nothing found, flip still reported.
        ask_nearest(QAZ_W'(-1), 12'd0);
        ask_nearest(QAZ_W'(-4096), QEL_W'(-2048));
        ask_nearest(13'd4095, 12'd2047);

        // Extreme elevations, a duplicated azimuth for a tie, and two slots
        // outside the searched range, one of them the top slot.
        write_entry(10'd0, 8'h80, 9'd0);
        write_entry(10'd1, 8'h7F, 9'd511);
        write_entry(10'd2, 8'd0, 9'd10);
        write_entry(10'd3, 8'd0, 9'd10);
        write_entry(10'd4, 8'd0, 9'd359);
        write_entry(10'd5, 8'h80, 9'd300);
        write_entry(10'd1023, 8'd90, 9'd255);
        write_entry(10'd682, ELEV_W'(-90), 9'd170);
        load_count(6);
        // Azimuth tie between slots 2 and 3: the earlier one wins.
        ask_nearest(13'd160, 12'd0);
        // Elevation tie halfway between -128 and 0 resolves to -128.
        ask_nearest(QAZ_W'(-4096), QEL_W'(-1024));
        ask_nearest(13'd4095, 12'd2047);
        ask_nearest(13'd0, QEL_W'(-2048));
        ask_nearest(QAZ_W'(-5744), 12'd5);
        // Exactly halfway between azimuths 10 and 359.
        ask_nearest(13'd2952, 12'd0);
        load_count(1);
        ask_nearest(pick_query_azim(), pick_query_elev());
        load_count(0);
        ask_nearest(QAZ_W'(-77), 12'd300);

        // Fill every slot once so that any count may be searched afterwards.
        refresh_pools();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            write_entry(SLOT_W'(i), pick_elev(), pick_azim());
        end

        words_sent = 0;
        phase = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            phase++;
            // First three phases search the whole table: full count, the
            // largest count, and a count past the table that must saturate.
            if (phase == 1)
            begin
                n = TABLE_DEPTH;
            end
            else if (phase == 2)
            begin
                n = 2047;
            end
            else if (phase == 3)
            begin
                n = $urandom_range(TABLE_DEPTH + 1, 2046);
            end
            else
            begin
                refresh_pools();
                case ($urandom_range(0, 9))
                    0:       n = 0;
                    1:       n = $urandom_range(25, 200);
                    default: n = $urandom_range(1, 24);
                endcase
                // Rebuild the searched entries around the new pools.
                if (n <= 24)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        write_entry(SLOT_W'(i), pick_elev(), pick_azim());
                    end
                end
                else
                begin
                    repeat (8) write_entry(SLOT_W'($urandom_range(0, n - 1)), pick_elev(),
                                           pick_azim());
                end
            end
            load_count(n);
            queries = (phase <= 3) ? 3 : int'($urandom_range(4, 10));
            for (int q = 0; q < queries; q++)
            begin
                idle_on = !(words_sent >= 120 && words_sent < 190);
                // Stray writes land anywhere, inside the searched range too.
                if ($urandom_range(0, 99) < 30)
                begin
                    write_entry(SLOT_W'($urandom_range(0, TABLE_DEPTH - 1)), pick_elev(),
                                pick_azim());
                end
                ask_nearest(pick_query_azim(), pick_query_elev());
            end
        end

        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        // Hold long enough for a full-table query to catch a stray done pulse.
        repeat (2 * TABLE_DEPTH + 10) @(posedge clk);
        if (board.mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hnds_pkg.sv
hdl/hnds_ram.sv
hdl/hrtf_nearest_direction_select.sv
tb/testbench.sv
